[hdl/hgc_pkg.sv]
package hgc_pkg;

    localparam int CORDIC_STAGES = 24;

    localparam int MAG_W  = 31;
    localparam int ANG_W  = 31;
    localparam int CW     = 34;
    localparam int DIV_W  = 64;
    localparam int DEN_W  = 34;
    localparam int ROOT_W = 31;
    localparam int SQ_W   = 61;
    localparam int RAD_W  = 23;
    localparam int DIST_W = 35;

    localparam logic [31:0]             PI_Q31_HALF  = 32'd3373259426;
    localparam logic [31:0]             RAD_RECIP    = 32'd4024455254;
    localparam logic [21:0]             DEN_ODD      = 22'd3515625;
    localparam logic [DEN_W-1:0]        DEN_FULL     = 34'd3600000000;
    localparam logic [DEN_W-1:0]        DEN_HALF     = 34'd7200000000;
    localparam logic signed [30:0]      LAT_LIMIT    = 31'sd900000000;
    localparam logic signed [32:0]      HALF_TURN    = 33'sd1800000000;
    localparam logic signed [32:0]      FULL_TURN    = 33'sd3600000000;
    localparam logic signed [CW-1:0]    CORDIC_KINV  = 34'sd652032875;
    localparam logic signed [CW-1:0]    ONE_S        = 34'sd1073741824;
    localparam logic [ANG_W-1:0]        ONE_Q30      = 31'd1073741824;
    localparam logic [RAD_W-1:0]        RADIUS_RESET = 23'd6371000;

    localparam int LAT_ANG = 4 + CORDIC_STAGES;
    localparam int N_LAT   = 2 + LAT_ANG + 4 + ROOT_W + CORDIC_STAGES + 2;

    function automatic logic signed [CW-1:0] atan_q30(input int i);
        logic signed [CW-1:0] t;
        unique case (i)
            0: t = 34'sd843314857;
            1: t = 34'sd497837829;
            2: t = 34'sd263043837;
            3: t = 34'sd133525159;
            4: t = 34'sd67021687;
            5: t = 34'sd33543516;
            6: t = 34'sd16775851;
            7: t = 34'sd8388437;
            8: t = 34'sd4194283;
            9: t = 34'sd2097149;
            default: t = (i <= 30) ? (34'sd1 <<< (30 - i)) : '0;
        endcase
        return t;
    endfunction

endpackage

[hdl/haversine_great_circle_distance_core.sv]
// Haversine great-circle distance, fully pipelined: one request enters per clock unless the output
// stalls, and its distance is given in millimetres. The pipeline holds the reciprocal-multiply
// degree-to-radian conversion, the sine/cosine CORDIC, the bit-per-stage square roots and the
// arctangent CORDIC. A stall at the output while a result waits there freezes the whole pipeline,
// so nothing is lost or repeated. Write the radius only while idle.
module haversine_great_circle_distance_core
    import hgc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [RAD_W-1:0]        i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [31:0]      i_from_lon,
    input  logic signed [30:0]      i_from_lat,
    input  logic signed [31:0]      i_to_lon,
    input  logic signed [30:0]      i_to_lat,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [DIST_W-1:0]       o_distance_mm
);

    function automatic logic [ANG_W-1:0] mul_q30(input logic [ANG_W-1:0] a,
                                                 input logic [ANG_W-1:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + 62'(1 << 29);
        return p[60:30];
    endfunction

    function automatic logic signed [30:0] clamp_lat(input logic signed [30:0] v);
        logic signed [30:0] r;
        if (v > LAT_LIMIT) begin
            r = LAT_LIMIT;
        end else if (v < -LAT_LIMIT) begin
            r = -LAT_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic               en;
    logic [N_LAT-1:0]   r_vld;
    logic [RAD_W-1:0]   r_radius;

    assign en          = !(r_vld[N_LAT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[N_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= RADIUS_RESET;
        end else begin
            if (en) begin
                r_vld <= {r_vld[N_LAT-2:0], i_in_valid};
            end
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
        end
    end

    logic signed [30:0] lat1_c, lat2_c;
    logic signed [31:0] dlat_c;
    logic signed [32:0] dlon_c;

    assign lat1_c = clamp_lat(i_from_lat);
    assign lat2_c = clamp_lat(i_to_lat);
    assign dlat_c = 32'(lat2_c) - 32'(lat1_c);
    assign dlon_c = 33'(i_to_lon) - 33'(i_from_lon);

    logic signed [30:0] r_lat1, r_lat2;
    logic signed [31:0] r_dlat;
    logic signed [32:0] r_dlon;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lat1 <= lat1_c;
            r_lat2 <= lat2_c;
            r_dlat <= dlat_c;
            r_dlon <= dlon_c;
        end
    end

    logic signed [32:0] dlon_w;
    logic signed [30:0] a_lat1, a_lat2;
    logic signed [31:0] a_dlat;
    logic signed [32:0] a_dlon;

    always_comb begin
        if (r_dlon > HALF_TURN) begin
            dlon_w = r_dlon - FULL_TURN;
        end else if (r_dlon < -HALF_TURN) begin
            dlon_w = r_dlon + FULL_TURN;
        end else begin
            dlon_w = r_dlon;
        end
        a_lat1 = r_lat1[30] ? -r_lat1 : r_lat1;
        a_lat2 = r_lat2[30] ? -r_lat2 : r_lat2;
        a_dlat = r_dlat[31] ? -r_dlat : r_dlat;
        a_dlon = dlon_w[32] ? -dlon_w : dlon_w;
    end

    logic [MAG_W-1:0] r_m_lat1, r_m_lat2, r_m_dlat, r_m_dlon;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_lat1 <= a_lat1[MAG_W-1:0];
            r_m_lat2 <= a_lat2[MAG_W-1:0];
            r_m_dlat <= a_dlat[MAG_W-1:0];
            r_m_dlon <= a_dlon[MAG_W-1:0];
        end
    end

    logic [ANG_W-1:0] c1, c2, sh, sn;

    hgc_angle u_lat1 (
        .i_clk (i_clk), .i_en (en), .i_half (1'b0), .i_mag (r_m_lat1),
        .o_cos (c1), .o_sin ()
    );
    hgc_angle u_lat2 (
        .i_clk (i_clk), .i_en (en), .i_half (1'b0), .i_mag (r_m_lat2),
        .o_cos (c2), .o_sin ()
    );
    hgc_angle u_dlat (
        .i_clk (i_clk), .i_en (en), .i_half (1'b1), .i_mag (r_m_dlat),
        .o_cos (), .o_sin (sh)
    );
    hgc_angle u_dlon (
        .i_clk (i_clk), .i_en (en), .i_half (1'b1), .i_mag (r_m_dlon),
        .o_cos (), .o_sin (sn)
    );

    logic [ANG_W-1:0] r_shsq, r_c12, r_snsq, r_shsq2, r_t, r_a;
    logic [ANG_W:0]   a_sum;
    logic [SQ_W-1:0]  r_va, r_vc;

    assign a_sum = {1'b0, r_shsq2} + {1'b0, r_t};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_shsq  <= mul_q30(sh, sh);
            r_c12   <= mul_q30(c1, c2);
            r_snsq  <= mul_q30(sn, sn);
            r_t     <= mul_q30(r_c12, r_snsq);
            r_shsq2 <= r_shsq;
            r_a     <= (a_sum > {1'b0, ONE_Q30}) ? ONE_Q30 : a_sum[ANG_W-1:0];
            r_va    <= {r_a, 30'd0};
            r_vc    <= {ONE_Q30 - r_a, 30'd0};
        end
    end

    logic [ROOT_W-1:0] root_s, root_c;

    hgc_isqrt u_sqrt_s (.i_clk (i_clk), .i_en (en), .i_val (r_va), .o_root (root_s));
    hgc_isqrt u_sqrt_c (.i_clk (i_clk), .i_en (en), .i_val (r_vc), .o_root (root_c));

    logic signed [CW-1:0] r_vx [CORDIC_STAGES-1];
    logic signed [CW-1:0] r_vy [CORDIC_STAGES-1];
    logic signed [CW-1:0] r_vz [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
        logic signed [CW-1:0] x_in, y_in, z_in, dx, dy, at;
        if (i == 0) begin : g_first
            assign x_in = $signed(CW'(root_c));
            assign y_in = $signed(CW'(root_s));
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_vx[i-1];
            assign y_in = r_vy[i-1];
            assign z_in = r_vz[i-1];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        assign at = atan_q30(i);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_vz[i] <= y_in[CW-1] ? (z_in - at) : (z_in + at);
            end
        end
        if (i < CORDIC_STAGES - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (!y_in[CW-1]) begin
                        r_vx[i] <= x_in + dx;
                        r_vy[i] <= y_in - dy;
                    end else begin
                        r_vx[i] <= x_in - dx;
                        r_vy[i] <= y_in + dy;
                    end
                end
            end
        end
    end

    logic signed [CW-1:0] z_fin;
    logic [ANG_W-1:0]     ang;
    logic [53:0]          r_q;
    logic [63:0]          scaled;
    logic [DIST_W-1:0]    r_dist;

    assign z_fin  = r_vz[CORDIC_STAGES-1];
    assign ang    = z_fin[CW-1] ? '0 : z_fin[ANG_W-1:0];
    assign scaled = (64'(r_q) << 7) - (64'(r_q) << 2) + 64'(r_q) + (64'd1 << 25);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q    <= 54'(r_radius) * 54'(ang);
            r_dist <= scaled[60:26];
        end
    end

    assign o_distance_mm = r_dist;

endmodule

[hdl/hgc_angle.sv]
module hgc_angle
    import hgc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_half,
    input  logic [MAG_W-1:0] i_mag,
    output logic [ANG_W-1:0] o_cos,
    output logic [ANG_W-1:0] o_sin
);

    function automatic logic [ANG_W-1:0] clamp_unit(input logic signed [CW-1:0] v);
        logic [ANG_W-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > ONE_S) begin
            r = ONE_Q30;
        end else begin
            r = v[ANG_W-1:0];
        end
        return r;
    endfunction

    logic [DIV_W-1:0] r_est_p;
    logic [DIV_W-1:0] r_prod;
    logic [31:0]      r_est;
    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_chk;
    logic [DIV_W-1:0] r_num2;
    logic [31:0]      r_est2;
    logic [ANG_W-1:0] r_theta;
    logic [DEN_W-1:0] den;
    logic [DIV_W-1:0] est_sum;
    logic [DIV_W-1:0] chk_sh;

    assign den     = i_half ? DEN_HALF : DEN_FULL;
    assign est_sum = r_est_p + (i_half ? (DIV_W'(1) << 31) : (DIV_W'(1) << 30));
    assign chk_sh  = i_half ? (r_chk << 11) : (r_chk << 10);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_est_p <= DIV_W'(i_mag) * DIV_W'(RAD_RECIP);
            r_prod  <= DIV_W'(i_mag) * DIV_W'(PI_Q31_HALF);
            r_est   <= i_half ? est_sum[63:32] : est_sum[62:31];
            r_num   <= {r_prod[DIV_W-2:0], 1'b0} + DIV_W'(den >> 1);
            r_chk   <= DIV_W'(r_est + 32'd1) * DIV_W'(DEN_ODD);
            r_num2  <= r_num;
            r_est2  <= r_est;
            r_theta <= (r_num2 >= chk_sh) ? ANG_W'(r_est2 + 32'd1) : r_est2[ANG_W-1:0];
        end
    end

    logic signed [CW-1:0] r_x [CORDIC_STAGES];
    logic signed [CW-1:0] r_y [CORDIC_STAGES];
    logic signed [CW-1:0] r_z [CORDIC_STAGES-1];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
        logic signed [CW-1:0] x_in, y_in, z_in, dx, dy, at;
        if (i == 0) begin : g_first
            assign x_in = CORDIC_KINV;
            assign y_in = '0;
            assign z_in = $signed(CW'(r_theta));
        end else begin : g_next
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        assign at = atan_q30(i);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!z_in[CW-1]) begin
                    r_x[i] <= x_in - dx;
                    r_y[i] <= y_in + dy;
                end else begin
                    r_x[i] <= x_in + dx;
                    r_y[i] <= y_in - dy;
                end
            end
        end
        if (i < CORDIC_STAGES - 1) begin : g_z
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_z[i] <= z_in[CW-1] ? (z_in + at) : (z_in - at);
                end
            end
        end
    end

    assign o_cos = clamp_unit(r_x[CORDIC_STAGES-1]);
    assign o_sin = clamp_unit(r_y[CORDIC_STAGES-1]);

endmodule

[hdl/hgc_isqrt.sv]
module hgc_isqrt
    import hgc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SQ_W-1:0]   i_val,
    output logic [ROOT_W-1:0] o_root
);

    logic [SQ_W-1:0]   r_rem  [ROOT_W-1];
    logic [ROOT_W-1:0] r_root [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
        localparam int B = ROOT_W - 1 - k;
        logic [SQ_W-1:0]   rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [63:0]       term;
        logic [64:0]       diff;
        if (k == 0) begin : g_first
            assign rem_in  = i_val;
            assign root_in = '0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
        end
        assign term = (64'(root_in) << (B + 1)) + (64'd1 << (2 * B));
        assign diff = {1'b0, 64'(rem_in)} - {1'b0, term};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_root[k] <= diff[64] ? root_in : (root_in | (ROOT_W'(1) << B));
            end
        end
        if (k < ROOT_W - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= diff[64] ? rem_in : diff[SQ_W-1:0];
                end
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

[hdl/hgc_checker.sv]
module hgc_checker
    import hgc_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [RAD_W-1:0]     i_cfg_wdata,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic signed [31:0]   i_from_lon,
    input logic signed [30:0]   i_from_lat,
    input logic signed [31:0]   i_to_lon,
    input logic signed [30:0]   i_to_lat,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [DIST_W-1:0]    o_distance_mm
);

    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked result");

    a_free_when_unblocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |-> !o_in_stall)
        else $error("input stalled while the result drains");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_distance_mm)))
        else $error("stalled result changed or dropped");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind haversine_great_circle_distance_core hgc_checker u_hgc_checker (.*);
